>>> src/assert_macros.svh
// Assertion macros used by the RTL of the keyed-removal queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FKR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define FKR_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> src/fkr_pkg.sv
// Shared types and constants of the keyed-removal queue.
package fkr_pkg;

   localparam int CAPACITY_DEFAULT     = 16;
   localparam int PAYLOAD_BITS_DEFAULT = 64;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int LETTER_W = 8;
   localparam int NUMBER_W = 16;
   localparam int KEY_W    = LETTER_W + NUMBER_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SCAN,
      S_SHIFT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [LETTER_W-1:0] letter;
   } key_type;

   typedef struct packed {
      status_type status;
      key_type    key;
   } res_type;

endpackage

>>> src/fkr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fkr_engine.sv
// Command sequencer: circular record store, key scan and gap closing.
`include "assert_macros.svh"

module fkr_engine #(
   parameter int CAPACITY     = fkr_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = fkr_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fkr_pkg::cmd_type        req_cmd,
   input  fkr_pkg::key_type        req_key,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic                    out_free,
   output logic                    res_valid,
   output fkr_pkg::res_type        res,
   output logic [PAYLOAD_BITS-1:0] res_payload
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int REC_W = fkr_pkg::KEY_W + PAYLOAD_BITS;

   fkr_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    iss_idx_ff, iss_idx_in;
   logic [PTR_W-1:0]    iss_phys_ff, iss_phys_in;
   logic                rvalid_ff, rvalid_in;
   logic [CNT_W-1:0]    rd_log_ff, rd_log_in;
   logic [PTR_W-1:0]    rd_phys_ff, rd_phys_in;
   logic [PTR_W-1:0]    wr_phys_ff, wr_phys_in;
   fkr_pkg::key_type    key_ff, key_in;
   fkr_pkg::res_type    res_ff, res_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;

   logic                ram_we;
   logic [PTR_W-1:0]    ram_waddr;
   logic [REC_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [PTR_W-1:0]    ram_raddr;
   logic [REC_W-1:0]    ram_rdata;

   logic                accept;
   logic                issue;
   logic                full;
   logic                empty;
   logic                match;
   logic [PTR_W:0]      tail_sum;
   logic [PTR_W-1:0]    tail;
   fkr_pkg::key_type    rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;

   function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
      inc_ptr = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   fkr_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept   = req_valid && req_ready;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign tail_sum = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(count_ff);
   assign tail     = (tail_sum >= (PTR_W + 1)'(CAPACITY)) ?
                     PTR_W'(tail_sum - (PTR_W + 1)'(CAPACITY)) : PTR_W'(tail_sum);
   assign rd_key   = fkr_pkg::key_type'(ram_rdata[REC_W-1 -: fkr_pkg::KEY_W]);
   assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
   assign match    = (rd_key == key_ff);

   // Outputs: handshake and memory port controls.
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      issue     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = tail;
      ram_wdata = {req_key, req_payload};
      ram_re    = 1'b0;
      ram_raddr = head_ff;
      unique case (state_ff)
         fkr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ram_we = (req_cmd == fkr_pkg::CMD_PUSH) && !full;
               ram_re = ((req_cmd == fkr_pkg::CMD_POP) || (req_cmd == fkr_pkg::CMD_REMOVE))
                        && !empty;
            end
         end
         fkr_pkg::S_POP: begin
         end
         fkr_pkg::S_SCAN, fkr_pkg::S_SHIFT: begin
            issue     = (iss_idx_ff < count_ff);
            ram_re    = issue;
            ram_raddr = iss_phys_ff;
            if (state_ff == fkr_pkg::S_SHIFT) begin
               ram_we    = rvalid_ff;
               ram_waddr = wr_phys_ff;
               ram_wdata = ram_rdata;
            end
         end
         fkr_pkg::S_RESULT: begin
            res_valid = out_free;
         end
         default: begin
         end
      endcase
   end

   // Next state and datapath.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      iss_idx_in  = iss_idx_ff;
      iss_phys_in = iss_phys_ff;
      rvalid_in   = 1'b0;
      rd_log_in   = rd_log_ff;
      rd_phys_in  = rd_phys_ff;
      wr_phys_in  = wr_phys_ff;
      key_in      = key_ff;
      res_in      = res_ff;
      res_pay_in  = res_pay_ff;
      unique case (state_ff)
         fkr_pkg::S_IDLE: begin
            if (accept) begin
               key_in         = req_key;
               res_in.status  = fkr_pkg::STAT_OK;
               res_in.key     = '0;
               res_pay_in     = '0;
               state_in       = fkr_pkg::S_RESULT;
               unique case (req_cmd)
                  fkr_pkg::CMD_PUSH: begin
                     if (full) begin
                        res_in.status = fkr_pkg::STAT_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  fkr_pkg::CMD_POP: begin
                     if (empty) begin
                        res_in.status = fkr_pkg::STAT_EMPTY;
                     end else begin
                        state_in = fkr_pkg::S_POP;
                     end
                  end
                  fkr_pkg::CMD_REMOVE: begin
                     if (empty) begin
                        res_in.status = fkr_pkg::STAT_EMPTY;
                     end else begin
                        iss_idx_in  = CNT_W'(1);
                        iss_phys_in = inc_ptr(head_ff);
                        rvalid_in   = 1'b1;
                        rd_log_in   = '0;
                        rd_phys_in  = head_ff;
                        state_in    = fkr_pkg::S_SCAN;
                     end
                  end
                  fkr_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         fkr_pkg::S_POP: begin
            res_in.key = rd_key;
            res_pay_in = rd_pay;
            head_in    = inc_ptr(head_ff);
            count_in   = count_ff - 1'b1;
            state_in   = fkr_pkg::S_RESULT;
         end
         fkr_pkg::S_SCAN, fkr_pkg::S_SHIFT: begin
            rvalid_in = issue;
            if (issue) begin
               iss_idx_in  = iss_idx_ff + 1'b1;
               iss_phys_in = inc_ptr(iss_phys_ff);
               rd_log_in   = iss_idx_ff;
               rd_phys_in  = iss_phys_ff;
            end
            if (state_ff == fkr_pkg::S_SCAN) begin
               if (rvalid_ff && match) begin
                  res_in.key = rd_key;
                  res_pay_in = rd_pay;
                  wr_phys_in = rd_phys_ff;
                  state_in   = fkr_pkg::S_SHIFT;
               end else if (rd_log_ff == count_ff - 1'b1) begin
                  res_in.status = fkr_pkg::STAT_NOT_FOUND;
                  state_in      = fkr_pkg::S_RESULT;
               end
            end else begin
               if (rvalid_ff) begin
                  wr_phys_in = inc_ptr(wr_phys_ff);
               end else if (!issue) begin
                  count_in = count_ff - 1'b1;
                  state_in = fkr_pkg::S_RESULT;
               end
            end
         end
         fkr_pkg::S_RESULT: begin
            if (out_free) begin
               state_in = fkr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fkr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fkr_pkg::S_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_idx_ff  <= iss_idx_in;
      iss_phys_ff <= iss_phys_in;
      rd_log_ff   <= rd_log_in;
      rd_phys_ff  <= rd_phys_in;
      wr_phys_ff  <= wr_phys_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      res_pay_ff  <= res_pay_in;
   end

   assign res         = res_ff;
   assign res_payload = res_pay_ff;

   `FKR_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "occupancy over capacity")
   `FKR_NEVER(a_no_rw_clash, clock, reset, ram_we && ram_re && (ram_waddr == ram_raddr), "read and write hit one entry")
   `FKR_ASSERT(a_pop_shrinks, clock, reset, (state_ff == fkr_pkg::S_POP) |=> (count_ff == CNT_W'($past(count_ff) - 1'b1)), "pop did not shrink queue")
   `FKR_ASSERT(a_scan_reads, clock, reset, (state_ff == fkr_pkg::S_SCAN) |-> rvalid_ff, "scan without read data")
   `FKR_ASSERT(a_shift_nonempty, clock, reset, (state_ff == fkr_pkg::S_SHIFT) |-> (count_ff != '0), "shift on empty queue")

endmodule

>>> src/fifo_with_keyed_removal.sv
// Top level of the ordered record queue with removal by key.
//
//  channel | direction | tdata fields, low bit up
//  req     | in        | cmd[1:0] key_letter[9:2] key_number[25:10] payload[+PAYLOAD_BITS]
//  rsp     | out       | status[1:0] out_letter[9:2] out_number[25:10] out_payload
//
// Push and clear go straight to the response; pop waits for the registered RAM read.
// Remove by key makes one RAM read per entry scanned, then one read and one
// write per entry behind the match.
// Reset empties the queue at once; no clearing pass.
// A waiting response holds in the output register while the next request runs.
module fifo_with_keyed_removal #(
   parameter int CAPACITY     = fkr_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = fkr_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // cmd, key_letter, key_number, payload; zero pad above
   input  logic [((fkr_pkg::CMD_W + fkr_pkg::KEY_W + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, out_letter, out_number, out_payload; zero pad above
   output logic [((fkr_pkg::STATUS_W + fkr_pkg::KEY_W + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int RSP_W = ((fkr_pkg::STATUS_W + fkr_pkg::KEY_W + PAYLOAD_BITS + 7) / 8) * 8;
   localparam int KEY_LO = fkr_pkg::CMD_W;
   localparam int PAY_LO = fkr_pkg::CMD_W + fkr_pkg::KEY_W;

   fkr_pkg::cmd_type        req_cmd;
   fkr_pkg::key_type        req_key;
   logic [PAYLOAD_BITS-1:0] req_payload;
   logic                    out_free;
   logic                    res_valid;
   fkr_pkg::res_type        res;
   logic [PAYLOAD_BITS-1:0] res_payload;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   assign req_cmd     = fkr_pkg::cmd_type'(req_tdata[fkr_pkg::CMD_W-1:0]);
   assign req_key     = fkr_pkg::key_type'(req_tdata[KEY_LO +: fkr_pkg::KEY_W]);
   assign req_payload = req_tdata[PAY_LO +: PAYLOAD_BITS];

   fkr_engine #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_payload (req_payload),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .res_payload (res_payload)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({res_payload, res.key.number, res.key.letter, res.status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
